// ===== rtl/core/jsu_pkg.sv =====
package jsu_pkg;

   // parser modes; unused encodings behave as waiting for the opening quote
   typedef enum logic [3:0] {
      M_IDLE      = 4'd0,
      M_STR       = 4'd1,
      M_ESC       = 4'd2,
      M_HEX_FIRST = 4'd3,
      M_WANT_BS   = 4'd4,
      M_WANT_U    = 4'd5,
      M_HEX_LOW   = 4'd6
   } mode_type;

   // result kinds
   typedef enum logic [1:0] {
      K_DATA  = 2'd0,
      K_CLOSE = 2'd1,
      K_ERR   = 2'd2
   } kind_type;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   // parser state carried from one byte to the next
   typedef struct packed {
      mode_type    mode;
      logic [15:0] hex_accum;
      logic [1:0]  digit_count;
      logic [9:0]  high_half;
   } state_type;

   localparam state_type ST_RESET = '{
      mode:        M_IDLE,
      hex_accum:   16'h0000,
      digit_count: 2'd0,
      high_half:   10'h000
   };

   // all results caused by one input byte; bytes[0] goes out first
   typedef struct packed {
      kind_type                     kind;
      logic [CNT_W-1:0]             count;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
   } group_type;

endpackage

// ===== rtl/core/jsu_decode.sv =====
module jsu_decode
   import jsu_pkg::*;
(
   input  state_type st,
   input  logic [7:0] in_byte,
   output state_type st_nxt,
   output group_type grp
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_U     = 8'h75;

   // one code point to 1..4 utf-8 bytes
   function automatic group_type utf8_encode(input logic [20:0] cp);
      group_type g;
      g = '0;
      g.kind = K_DATA;
      if (cp < 21'h000080) begin
         g.count    = CNT_W'(1);
         g.bytes[0] = cp[7:0];
      end else if (cp < 21'h000800) begin
         g.count    = CNT_W'(2);
         g.bytes[0] = {3'b110, cp[10:6]};
         g.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h010000) begin
         g.count    = CNT_W'(3);
         g.bytes[0] = {4'b1110, cp[15:12]};
         g.bytes[1] = {2'b10, cp[11:6]};
         g.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         g.count    = CNT_W'(4);
         g.bytes[0] = {5'b11110, cp[20:18]};
         g.bytes[1] = {2'b10, cp[17:12]};
         g.bytes[2] = {2'b10, cp[11:6]};
         g.bytes[3] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

   // hex digit of either case; bit 4 flags a valid digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h00;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, b[3:0]};
      end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, 4'(b[3:0] + 4'd9)};
      end
      return r;
   endfunction

   logic [4:0]  digit;
   logic [15:0] acc_new;
   logic [20:0] cp_pair;
   logic        err;

   assign digit   = hex_digit(in_byte);
   assign acc_new = {st.hex_accum[11:0], digit[3:0]};
   // surrogate pair: 0x10000 + ((high - 0xD800) << 10) + (low - 0xDC00)
   assign cp_pair = {1'b0, st.high_half, acc_new[9:0]} + 21'h010000;

   // next state and results for one byte
   always_comb begin
      st_nxt    = st;
      grp       = '0;
      grp.kind  = K_DATA;
      err       = 1'b0;
      case (st.mode)
         M_STR: begin
            if (in_byte == CH_QUOTE) begin
               grp.kind  = K_CLOSE;
               grp.count = CNT_W'(1);
               st_nxt    = ST_RESET;
            end else if (in_byte == CH_BSL) begin
               st_nxt.mode = M_ESC;
            end else if (in_byte < 8'h20) begin
               err = 1'b1;
            end else begin
               grp.count    = CNT_W'(1);
               grp.bytes[0] = in_byte;
            end
         end
         M_ESC: begin
            st_nxt.mode = M_STR;
            grp.count   = CNT_W'(1);
            case (in_byte)
               CH_QUOTE: grp.bytes[0] = CH_QUOTE;
               CH_BSL:   grp.bytes[0] = CH_BSL;
               CH_SLASH: grp.bytes[0] = CH_SLASH;
               8'h6E:    grp.bytes[0] = 8'h0A;
               8'h74:    grp.bytes[0] = 8'h09;
               8'h72:    grp.bytes[0] = 8'h0D;
               8'h62:    grp.bytes[0] = 8'h08;
               8'h66:    grp.bytes[0] = 8'h0C;
               CH_U: begin
                  grp.count          = '0;
                  st_nxt.hex_accum   = 16'h0000;
                  st_nxt.digit_count = 2'd0;
                  st_nxt.mode        = M_HEX_FIRST;
               end
               default: err = 1'b1;
            endcase
         end
         M_HEX_FIRST, M_HEX_LOW: begin
            if (!digit[4]) begin
               err = 1'b1;
            end else if (st.digit_count != 2'd3) begin
               st_nxt.hex_accum   = acc_new;
               st_nxt.digit_count = st.digit_count + 2'd1;
            end else begin
               st_nxt.hex_accum   = acc_new;
               st_nxt.digit_count = 2'd0;
               if (st.mode == M_HEX_FIRST) begin
                  if (acc_new inside {[16'hDC00:16'hDFFF]}) begin
                     err = 1'b1;
                  end else if (acc_new inside {[16'hD800:16'hDBFF]}) begin
                     st_nxt.high_half = acc_new[9:0];
                     st_nxt.mode      = M_WANT_BS;
                  end else begin
                     grp         = utf8_encode({5'b00000, acc_new});
                     st_nxt.mode = M_STR;
                  end
               end else begin
                  if (acc_new inside {[16'hDC00:16'hDFFF]}) begin
                     grp         = utf8_encode(cp_pair);
                     st_nxt.mode = M_STR;
                  end else begin
                     err = 1'b1;
                  end
               end
            end
         end
         M_WANT_BS: begin
            if (in_byte == CH_BSL) begin
               st_nxt.mode = M_WANT_U;
            end else begin
               err = 1'b1;
            end
         end
         M_WANT_U: begin
            if (in_byte == CH_U) begin
               st_nxt.hex_accum   = 16'h0000;
               st_nxt.digit_count = 2'd0;
               st_nxt.mode        = M_HEX_LOW;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            // waiting for the opening quote
            if (in_byte == CH_QUOTE) begin
               st_nxt      = ST_RESET;
               st_nxt.mode = M_STR;
            end else begin
               err = 1'b1;
            end
         end
      endcase

      // any violation gives a lone error and restarts
      if (err) begin
         grp       = '0;
         grp.kind  = K_ERR;
         grp.count = CNT_W'(1);
         st_nxt    = ST_RESET;
      end
   end

endmodule

// ===== rtl/core/jsu_out_queue.sv =====
module jsu_out_queue
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  group_type  grp,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   kind_type                    kind_ff, kind_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic                        take;

   assign take      = rsp_valid && !rsp_stall;
   // free for a new group once the last pending word leaves this cycle
   assign ready     = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && !rsp_stall);
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_kind  = kind_ff;
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_last  = (cnt_ff == CNT_W'(1));

   // load a group or shift out one word
   always_comb begin
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      bytes_in = bytes_ff;
      if (load) begin
         cnt_in   = grp.count;
         kind_in  = grp.kind;
         bytes_in = grp.bytes;
      end else if (take) begin
         cnt_in   = cnt_ff - CNT_W'(1);
         bytes_in = {8'h00, bytes_ff[MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      bytes_ff <= bytes_in;
   end

endmodule

// ===== rtl/core/json_string_unescape_core.sv =====
// JSON string literal unescaper, one raw byte per input word.
// Input channel req_*: one byte of the quoted literal per word. The first
// byte must be the opening quote; escapes and \uXXXX (with surrogate pairs)
// are decoded and each code point comes out as 1 to 4 UTF-8 bytes.
// Result channel rsp_*: one word per output byte (kind data), or a single
// close word on the closing quote, or a single error word on any violation.
// rsp_last marks the final word caused by one input byte; bytes such as the
// opening quote, a backslash or early hex digits cause no word at all.
// Path: an accepted byte is held in the input register, then decoded
// combinationally into the group register that offers its result words.
// Throughput: one input byte per cycle without rsp_stall, while each byte
// gives at most one word; a byte that yields more words holds the input
// while the single result port drains the group register one word per cycle.
// Stall on rsp_stall holds the current word and backs up into req_stall
// once the input register is also full.
// Reset (synchronous): both registers empty, parser waits for a quote.
module json_string_unescape_core
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   state_type  st_ff, st_in;
   group_type  grp;
   logic       q_ready;
   logic       advance;

   assign advance   = in_valid_ff && q_ready;
   assign req_stall = in_valid_ff && !q_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   jsu_decode u_decode (
      .st      (st_ff),
      .in_byte (in_byte_ff),
      .st_nxt  (st_in),
      .grp     (grp)
   );

   jsu_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .grp          (grp),
      .ready        (q_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/core/jsu_checker.sv =====
module jsu_checker
   import jsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // close and error words stand alone and carry a zero byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != K_DATA) |-> rsp_last && (rsp_out_byte == 8'h00))
      else $error("close or error word malformed");

   // a utf-8 burst continues without a gap, and only with data words
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && (rsp_kind == K_DATA))
      else $error("multi-byte burst broken");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_kind     (rsp_kind),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import jsu_pkg::*;

   localparam int LIMIT_CYCLES = 100000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 300;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   // predicted parser state and the words it still owes: {kind, byte, last}
   state_type   parser = ST_RESET;
   logic [10:0] expected_words[$];
   logic [9:0]  group_buf[0:3];
   int          group_n;

   int   items_sent = 0;
   int   fail_count = 0;
   int   cycles = 0;
   bit   send_gaps = 1'b1;
   bit   recv_gaps = 1'b1;
   bit   hold_flag = 1'b0;
   bit   hold_seen = 1'b0;
   int   hold_len = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   logic [10:0] want_word;

   json_string_unescape_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always #4 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - 8'h30);
      if (b >= "a" && b <= "f") return int'(b - 8'h61) + 10;
      if (b >= "A" && b <= "F") return int'(b - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void push_result(kind_type k, logic [7:0] d);
      group_buf[group_n] = {k, d};
      group_n = group_n + 1;
   endfunction

   // utf-8 encoding of one code point
   function automatic void push_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
         push_result(K_DATA, cp[7:0]);
      end else if (cp < 21'h800) begin
         push_result(K_DATA, {3'b110, cp[10:6]});
         push_result(K_DATA, {2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         push_result(K_DATA, {4'b1110, cp[15:12]});
         push_result(K_DATA, {2'b10, cp[11:6]});
         push_result(K_DATA, {2'b10, cp[5:0]});
      end else begin
         push_result(K_DATA, {5'b11110, cp[20:18]});
         push_result(K_DATA, {2'b10, cp[17:12]});
         push_result(K_DATA, {2'b10, cp[11:6]});
         push_result(K_DATA, {2'b10, cp[5:0]});
      end
   endfunction

   // advance the parser by one accepted byte and queue the words it yields
   function automatic void decode_byte(logic [7:0] b);
      int         digit;
      logic       bad;
      logic [15:0] acc;
      group_n = 0;
      bad = 1'b0;
      case (parser.mode)
         M_STR: begin
            if (b == CH_QUOTE) begin
               push_result(K_CLOSE, 8'h00);
               parser = ST_RESET;
            end else if (b == CH_BSLASH) begin
               parser.mode = M_ESC;
            end else if (b < CH_SPACE) begin
               bad = 1'b1;
            end else begin
               push_result(K_DATA, b);
            end
         end
         M_ESC: begin
            parser.mode = M_STR;
            case (b)
               CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(K_DATA, b);
               "n": push_result(K_DATA, 8'h0A);
               "t": push_result(K_DATA, 8'h09);
               "r": push_result(K_DATA, 8'h0D);
               "b": push_result(K_DATA, 8'h08);
               "f": push_result(K_DATA, 8'h0C);
               "u": begin
                  parser.hex_accum = 16'h0000;
                  parser.digit_count = 2'd0;
                  parser.mode = M_HEX_FIRST;
               end
               default: bad = 1'b1;
            endcase
         end
         M_HEX_FIRST, M_HEX_LOW: begin
            digit = hex_value(b);
            if (digit < 0) begin
               bad = 1'b1;
            end else begin
               acc = {parser.hex_accum[11:0], digit[3:0]};
               parser.hex_accum = acc;
               if (parser.digit_count != 2'd3) begin
                  parser.digit_count = parser.digit_count + 2'd1;
               end else begin
                  parser.digit_count = 2'd0;
                  if (parser.mode == M_HEX_FIRST) begin
                     if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                        bad = 1'b1;
                     end else if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                        parser.high_half = acc[9:0];
                        parser.mode = M_WANT_BS;
                     end else begin
                        push_code_point({5'd0, acc});
                        parser.mode = M_STR;
                     end
                  end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                     bad = 1'b1;
                  end else begin
                     // both surrogate bases have zero low ten bits
                     push_code_point(21'h10000 + {1'b0, parser.high_half, acc[9:0]});
                     parser.mode = M_STR;
                  end
               end
            end
         end
         M_WANT_BS: begin
            if (b == CH_BSLASH) parser.mode = M_WANT_U;
            else bad = 1'b1;
         end
         M_WANT_U: begin
            if (b == "u") begin
               parser.hex_accum = 16'h0000;
               parser.digit_count = 2'd0;
               parser.mode = M_HEX_LOW;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            if (b == CH_QUOTE) begin
               parser = ST_RESET;
               parser.mode = M_STR;
            end else begin
               bad = 1'b1;
            end
         end
      endcase
      if (bad) begin
         push_result(K_ERR, 8'h00);
         parser = ST_RESET;
      end
      for (int i = 0; i < group_n; i++)
         expected_words.push_back({group_buf[i], i == group_n - 1});
   endfunction

   // ---------------- checking ----------------

   task automatic note_failure(input string msg);
      fail_count = fail_count + 1;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            note_failure($sformatf("unexpected word: kind %0d byte %02h last %0d",
                                   rsp_kind, rsp_out_byte, rsp_last));
         end else begin
            want_word = expected_words.pop_front();
            if (rsp_kind !== want_word[10:9] || rsp_out_byte !== want_word[8:1] ||
                rsp_last !== want_word[0])
               note_failure($sformatf(
                  "word mismatch: kind %0d/%0d byte %02h/%02h last %0d/%0d (want/got)",
                  want_word[10:9], rsp_kind, want_word[8:1], rsp_out_byte,
                  want_word[0], rsp_last));
         end
      end
   end

   // receiver stall: random wait before each word, plus requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_flag != hold_seen) begin
            hold_seen = hold_flag;
            hold_left = hold_len;
         end
         if (rsp_valid && !rsp_stall) stall_left = recv_gaps ? $urandom_range(0, 6) : 0;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = send_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      decode_byte(b);
      items_sent = items_sent + 1;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // sender pause until every predicted word is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + (n - 4'd10);
   endfunction

   task automatic send_unicode(input logic [15:0] v);
      send_byte(CH_BSLASH);
      send_byte("u");
      for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]));
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return "n";
         4: return "t";
         5: return "r";
         6: return "b";
         default: return "f";
      endcase
   endfunction

   function automatic bit is_escape_letter(logic [7:0] b);
      return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == "n" ||
             b == "t" || b == "r" || b == "b" || b == "f" || b == "u";
   endfunction

   // code point outside the surrogate range, boundaries now and then
   function automatic logic [15:0] bmp_code();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 16'h7F));
         1: return 16'($urandom_range(16'h80, 16'h7FF));
         2: return 16'($urandom_range(16'h800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         4: return ($urandom_range(0, 1)) ? 16'h0000 : 16'h007F;
         5: return ($urandom_range(0, 1)) ? 16'h0080 : 16'h07FF;
         6: return ($urandom_range(0, 1)) ? 16'h0800 : 16'hD7FF;
         default: return ($urandom_range(0, 1)) ? 16'hE000 : 16'hFFFF;
      endcase
   endfunction

   function automatic logic [9:0] surrogate_half();
      case ($urandom_range(0, 3))
         0: return 10'h000;
         1: return 10'h3FF;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // one malformed construct inside an open literal; ends the literal
   task automatic send_broken();
      logic [7:0] b;
      int         n;
      case ($urandom_range(0, 6))
         0: send_byte(8'($urandom_range(0, 31)));
         1: begin
            do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
            send_byte(CH_BSLASH);
            send_byte(b);
         end
         2: begin
            n = $urandom_range(0, 3);
            send_byte(CH_BSLASH);
            send_byte("u");
            repeat (n) send_byte(hex_char(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
            send_byte(b);
         end
         3: send_unicode(16'hDC00 | 16'(surrogate_half()));
         4: begin
            send_unicode(16'hD800 | 16'(surrogate_half()));
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
            send_byte(b);
         end
         5: begin
            send_unicode(16'hD800 | 16'(surrogate_half()));
            send_byte(CH_BSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == "u");
            send_byte(b);
         end
         default: begin
            send_unicode(16'hD800 | 16'(surrogate_half()));
            send_unicode($urandom_range(0, 1) ? bmp_code() :
                         (16'hD800 | 16'(surrogate_half())));
         end
      endcase
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      send_byte("x");                      // not a quote while waiting
      send_text("\" ");
      send_byte(8'hFF);
      send_text("\\uD83D\\udE00\\u0000");  // surrogate pair, then nul escape
      send_byte(8'h1F);                    // raw control byte
      send_text("\"\"");                   // empty literal
      send_text("\"\\q");                  // unknown escape letter
   endtask

   // well-formed literals with random content, some broken, some noise between
   task automatic test_random_literals(input int budget);
      int  start;
      int  pick;
      bit  in_str;
      logic [7:0] b;
      start = items_sent;
      while (items_sent - start < budget) begin
         send_byte(CH_QUOTE);
         in_str = 1'b1;
         while (in_str) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_byte(plain_byte());
            end else if (pick < 55) begin
               send_byte(CH_BSLASH);
               send_byte(escape_letter());
            end else if (pick < 70) begin
               send_unicode(bmp_code());
            end else if (pick < 80) begin
               send_unicode(16'hD800 | 16'(surrogate_half()));
               send_unicode(16'hDC00 | 16'(surrogate_half()));
            end else if (pick < 90) begin
               send_byte(CH_QUOTE);
               in_str = 1'b0;
            end else begin
               send_broken();
               in_str = 1'b0;
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            send_byte(b);
         end
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
   endtask

   // receiver holds off while three-byte characters keep arriving
   task automatic test_long_backpressure();
      send_gaps = 1'b0;
      hold_len = LONG_HOLD;
      hold_flag = ~hold_flag;
      send_byte(CH_QUOTE);
      repeat (6) send_unicode(16'h20AC);
      send_byte(CH_QUOTE);
      wait_drained();
      send_gaps = 1'b1;
   endtask

   // sender goes quiet mid-literal and mid-escape until all words are out
   task automatic test_pause_for_drain();
      send_text("\"ab");
      wait_drained();
      send_text("\\u00");
      wait_drained();
      send_text("e9");
      wait_drained();
      send_byte(CH_QUOTE);
      wait_drained();
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_literals(110);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      test_random_literals(100);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      test_long_backpressure();
      test_pause_for_drain();
      test_random_literals(90);
      finish_run();
   end

endmodule
